[rtl/core/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator: request and
// status codes, register map and the configuration bundle.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // default pool geometry
    localparam int POOL_BYTES_DEF = 4096;
    localparam int MAX_BLOCKS_DEF = 512;

    // block size register
    localparam int                BSL_W     = 4;
    localparam logic [BSL_W-1:0]  BSL_RESET = 4'd5;

    // register port
    localparam int               APB_DATA_W = 32;
    localparam int               APB_ADDR_W = 3;
    localparam logic             REG_IDX_BLOCK_SIZE = 1'b0;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam int              STATUS_W       = 2;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // configuration bundle from the register block
    typedef struct packed {
        logic [BSL_W-1:0] bsl;       // current block size log2
        logic             load;      // register written this cycle
        logic [BSL_W-1:0] load_bsl;  // value being written
    } cfg_t;

endpackage

[rtl/core/fbpa_if.sv]
// ----------------------------------------------------------------------------
// fbpa request and response channels
// Valid/ready channels carrying one allocator request and one result.
// ----------------------------------------------------------------------------
interface fbpa_req_if
    import fbpa_pkg::*;
#(
    parameter int OFS_W = $clog2(POOL_BYTES_DEF)
);
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [OFS_W-1:0] free_offset;

    modport source (output valid, output req_type, output free_offset, input ready);
    modport sink   (input valid, input req_type, input free_offset, output ready);
endinterface

interface fbpa_rsp_if
    import fbpa_pkg::*;
#(
    parameter int OFS_W = $clog2(POOL_BYTES_DEF),
    parameter int CNT_W = $clog2(MAX_BLOCKS_DEF) + 1
);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFS_W-1:0]    block_offset;
    logic [CNT_W-1:0]    blocks_free;

    modport source (output valid, output status, output block_offset,
                    output blocks_free, input ready);
    modport sink   (input valid, input status, input block_offset,
                    input blocks_free, output ready);
endinterface

[rtl/core/fbpa_ram.sv]
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fbpa_ram
    import fbpa_pkg::*;
#(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/fbpa_cfg.sv]
// ----------------------------------------------------------------------------
// fbpa_cfg
// Register block: holds block_size_log2 behind an APB-style port and flags
// each write so the pool can be rebuilt.
// ----------------------------------------------------------------------------
module fbpa_cfg
    import fbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic             hit;
    logic             wr_en;
    logic [BSL_W-1:0] bsl_reg;
    logic [BSL_W-1:0] bsl_next;

    // word index decode, byte lane bits ignored
    assign hit    = (paddr[APB_ADDR_W-1] == REG_IDX_BLOCK_SIZE);
    assign wr_en  = psel && penable && pwrite && hit;
    assign pready = 1'b1;

    assign bsl_next = wr_en ? pwdata[BSL_W-1:0] : bsl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsl_reg <= BSL_RESET;
        end
        else
        begin
            bsl_reg <= bsl_next;
        end
    end

    // read back
    assign prdata = hit ? APB_DATA_W'(bsl_reg) : '0;

    assign cfg.bsl      = bsl_reg;
    assign cfg.load     = wr_en;
    assign cfg.load_bsl = pwdata[BSL_W-1:0];

endmodule

[rtl/core/fixed_block_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator over a byte pool. Frees go onto a LIFO list
// kept in a link RAM; allocates pop that list or take the next untouched block.
//
//   channel  | dir | transfer when          | payload
//   ---------+-----+------------------------+---------------------------------
//   req      | in  | valid && ready         | req_type, free_offset
//   rsp      | out | valid && ready         | status, block_offset, blocks_free
//   apb      | in  | psel,penable,pwrite    | block_size_log2 at word 0
//
// A free, a failed allocate or an allocate of an untouched block is done in
// S_IDLE; an allocate from the free list also passes through S_LINK, waiting on
// the registered read of the link RAM for the new list head.
// The result register is loaded as the request is taken; a stalled result
// holds off the next request. Reset and any block size write leave the pool
// full, with no sweep of the link RAM.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int POOL_BYTES = POOL_BYTES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fbpa_req_if.sink              req,
    fbpa_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int OFS_W = $clog2(POOL_BYTES);
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;
    localparam int SH_W  = (OFS_W + 1 > CNT_W) ? OFS_W + 1 : CNT_W;

    typedef enum logic {S_IDLE, S_LINK} state_t;

    // blocks in the pool for a given block size, capped
    function automatic logic [CNT_W-1:0] count_for(input logic [BSL_W-1:0] sz);
        logic [SH_W-1:0] raw;
        raw = SH_W'(POOL_BYTES) >> sz;
        if (raw > SH_W'(MAX_BLOCKS))
        begin
            return CNT_W'(MAX_BLOCKS);
        end
        return raw[CNT_W-1:0];
    endfunction

    cfg_t cfg;

    state_t              state_reg,     state_next;
    logic [IDX_W-1:0]    head_reg,      head_next;
    logic                nonempty_reg,  nonempty_next;
    logic [CNT_W-1:0]    mark_reg,      mark_next;
    logic [CNT_W-1:0]    free_reg,      free_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg,    status_next;
    logic [OFS_W-1:0]    offset_reg,    offset_next;
    logic [CNT_W-1:0]    bfree_reg,     bfree_next;

    logic [CNT_W-1:0] blocks;
    logic             accept;
    logic             is_alloc;
    logic             list_ok;
    logic             fresh_ok;
    logic [OFS_W-1:0] lane_mask;
    logic [OFS_W-1:0] off_idx;
    logic             free_bad;
    logic [IDX_W-1:0] grant_idx;
    logic [SH_W-1:0]  grant_wide;
    logic             ram_en;
    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [IDX_W-1:0] ram_rdata;

    // register block
    fbpa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // free list links
    fbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head_reg),
        .rdata (ram_rdata)
    );

    // request handshake
    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready) && !cfg.load;
    assign accept    = req.valid && req.ready;
    assign is_alloc  = (req.req_type == REQ_ALLOC);

    // pool decisions
    assign blocks    = count_for(cfg.bsl);
    assign list_ok   = nonempty_reg && (free_reg != '0);
    assign fresh_ok  = (mark_reg < blocks) && (free_reg != '0);
    assign lane_mask = ~({OFS_W{1'b1}} << cfg.bsl);
    assign off_idx   = req.free_offset >> cfg.bsl;
    assign free_bad  = (|(req.free_offset & lane_mask))
                     || (SH_W'(off_idx) >= SH_W'(mark_reg))
                     || (free_reg >= blocks);

    // granted block and its byte offset
    assign grant_idx  = list_ok ? head_reg : mark_reg[IDX_W-1:0];
    assign grant_wide = SH_W'(grant_idx) << cfg.bsl;

    // link RAM: pop reads the head's link, push writes the old head
    assign ram_en   = accept && (is_alloc ? list_ok : !free_bad);
    assign ram_we   = !is_alloc;
    assign ram_addr = is_alloc ? head_reg : IDX_W'(off_idx);

    // next state
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        nonempty_next  = nonempty_reg;
        mark_next      = mark_reg;
        free_next      = free_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        offset_next    = offset_reg;
        bfree_next     = bfree_reg;

        if (cfg.load)
        begin
            head_next     = '0;
            nonempty_next = 1'b0;
            mark_next     = '0;
            free_next     = count_for(cfg.load_bsl);
        end
        else if (state_reg == S_LINK)
        begin
            head_next  = ram_rdata;
            state_next = S_IDLE;
        end
        else if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_DONE;
            offset_next    = '0;
            if (is_alloc)
            begin
                priority if (list_ok)
                begin
                    free_next     = free_reg - 1'b1;
                    nonempty_next = (free_reg - 1'b1) > (blocks - mark_reg);
                    offset_next   = grant_wide[OFS_W-1:0];
                    state_next    = S_LINK;
                end
                else if (fresh_ok)
                begin
                    mark_next   = mark_reg + 1'b1;
                    free_next   = free_reg - 1'b1;
                    offset_next = grant_wide[OFS_W-1:0];
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            else
            begin
                if (free_bad)
                begin
                    status_next = ST_BAD_FREE;
                end
                else
                begin
                    head_next     = IDX_W'(off_idx);
                    nonempty_next = 1'b1;
                    free_next     = free_reg + 1'b1;
                end
            end
            bfree_next = free_next;
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            mark_reg      <= '0;
            free_reg      <= count_for(BSL_RESET);
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_DONE;
            offset_reg    <= '0;
            bfree_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            mark_reg      <= mark_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            offset_reg    <= offset_next;
            bfree_reg     <= bfree_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.block_offset = offset_reg;
    assign rsp.blocks_free  = bfree_reg;

endmodule

[rtl/core/fbpa_checker.sv]
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks for the fixed block pool allocator, bound to the top.
// ----------------------------------------------------------------------------
module fbpa_checker
    import fbpa_pkg::*;
#(
    parameter int OFS_W = 12,
    parameter int CNT_W = 10
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [OFS_W-1:0]    block_offset,
    input logic [CNT_W-1:0]    blocks_free
);

    // every taken request shows a result on the next cycle
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("request transfer without a result");

    // a stalled result blocks new requests
    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while result stalled");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(block_offset) && $stable(blocks_free))
        else $error("stalled result changed");

    // a failed allocate or bad free never grants an offset
    a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> (status == ST_DONE) || (block_offset == '0))
        else $error("offset granted with error status");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
    .OFS_W (OFS_W),
    .CNT_W (CNT_W)
) u_fbpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .block_offset (rsp.block_offset),
    .blocks_free  (rsp.blocks_free)
);
